### src/xor_basis_max_split_sum_top_defines.svh
// assertion macros for the xor basis block
// used by xbs_cell and xor_basis_max_split_sum_top; depends on nothing
`ifndef XOR_BASIS_MAX_SPLIT_SUM_TOP_DEFINES_SVH
`define XOR_BASIS_MAX_SPLIT_SUM_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define XBS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xbs assertion failed");

// next-cycle implication
`define XBS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xbs assertion failed");

`else

`define XBS_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define XBS_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### src/xbs_pkg.sv
// shared constants and types for the xor basis block
// no dependencies
package xbs_pkg;

   // word width and derived widths
   localparam int WORD_BITS = 61;
   localparam int SUM_BITS  = WORD_BITS + 1;
   localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

   // what a transaction in the cell chain does at each cell
   typedef enum logic [0:0] {
      MODE_INSERT,
      MODE_MAX
   } mode_type;

   // one item travelling down the chain
   typedef struct packed {
      logic                 valid;
      mode_type             mode;
      logic [WORD_BITS-1:0] data;
   } link_type;

   // saved basis vector shifted up the chain during re-reduction
   typedef struct packed {
      logic                 has;
      logic [WORD_BITS-1:0] vec;
   } old_type;

   // controls broadcast from the sequencer to every cell
   typedef struct packed {
      logic clear;
      logic load_old;
      logic shift_old;
   } ctl_type;

endpackage

### src/xbs_req_if.sv
// input channel: one word per transaction, last word of a set marked
// depends on xbs_pkg
interface xbs_req_if import xbs_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WORD_BITS-1:0] word_value;
   logic                 last_word;

   modport source (output valid, output word_value, output last_word, input ready);
   modport sink   (input valid, input word_value, input last_word, output ready);
endinterface

### src/xbs_rsp_if.sv
// result channel: one sum per finished set
// depends on xbs_pkg
interface xbs_rsp_if import xbs_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SUM_BITS-1:0] best_sum;

   modport source (output valid, output best_sum, input ready);
   modport sink   (input valid, input best_sum, output ready);
endinterface

### src/xor_basis_max_split_sum_top.sv
// top level of the xor basis max split sum block: sequencer and cell chain
// depends on xbs_pkg, xbs_req_if, xbs_rsp_if, xbs_cell and the defines header
//
//   channel   dir  payload                   handshake
//   req_chan  in   word_value, last_word     valid / ready
//   rsp_chan  out  best_sum                  valid / ready
//
// an unmarked word is taken whenever the block is idle; words stream into the cell chain back to back
// a marked word starts a chain drain, then re-reduction of the masked basis through the
// chain, then one max scan down it
// req_chan.ready is low from a marked word until its sum sits in the output register
// a sum waiting in the output register does not block the next set's words
// reset is synchronous; valid bits clear at once, no clearing pass
`include "xor_basis_max_split_sum_top_defines.svh"

module xor_basis_max_split_sum_top import xbs_pkg::*; (
   input logic      clock,
   input logic      reset,
   xbs_req_if.sink  req_chan,
   xbs_rsp_if.source rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_REDUCE,
      ST_MAXQ,
      ST_FLUSH,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   link_type             inj_ff, inj_in;
   logic [WORD_BITS-1:0] running_xor_ff, running_xor_in;
   logic [WORD_BITS-1:0] s1_ff, s1_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SUM_BITS-1:0]  rsp_sum_ff, rsp_sum_in;

   link_type             links [WORD_BITS:0];
   old_type              olds  [WORD_BITS-1:0];
   ctl_type              ctl;
   logic                 req_accept;
   logic                 exit_token;
   logic [SUM_BITS-1:0]  sum;

   assign req_accept = req_chan.valid && req_chan.ready;
   assign exit_token = links[0].valid && links[0].mode == MODE_MAX;
   assign sum        = SUM_BITS'(s1_ff) + SUM_BITS'(s1_ff | running_xor_ff);

   // cell controls
   always_comb begin
      ctl.clear     = exit_token;
      ctl.load_old  = (state_ff == ST_DRAIN) && (cnt_ff == CNT_BITS'(WORD_BITS));
      ctl.shift_old = (state_ff == ST_REDUCE);
   end

   // chain of pivot cells, highest bit at the top
   assign links[WORD_BITS] = inj_ff;

   for (genvar b = 0; b < WORD_BITS; b++) begin : g_cell
      old_type below;
      if (b == 0) begin : g_bottom
         assign below = '0;
      end else begin : g_inner
         assign below = olds[b-1];
      end
      xbs_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .bit_sel  (WORD_BITS'(1) << b),
         .ctl      (ctl),
         .link_in  (links[b+1]),
         .link_out (links[b]),
         .old_in   (below),
         .old_out  (olds[b])
      );
   end

   // sequencer next state, injection register and output register
   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      inj_in         = inj_ff;
      inj_in.valid   = 1'b0;
      running_xor_in = running_xor_ff;
      s1_in          = s1_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_sum_in     = rsp_sum_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               inj_in         = '{valid: 1'b1, mode: MODE_INSERT,
                                  data: req_chan.word_value};
               running_xor_in = running_xor_ff ^ req_chan.word_value;
               if (req_chan.last_word) begin
                  state_in = ST_DRAIN;
                  cnt_in   = '0;
               end
            end
         end
         ST_DRAIN: begin
            // wait until the last word has passed every cell
            if (cnt_ff == CNT_BITS'(WORD_BITS)) begin
               state_in = ST_REDUCE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         ST_REDUCE: begin
            // feed saved vectors, masked with not t, into the cleared chain
            inj_in = '{valid: olds[WORD_BITS-1].has, mode: MODE_INSERT,
                       data: olds[WORD_BITS-1].vec & ~running_xor_ff};
            if (cnt_ff == CNT_BITS'(WORD_BITS - 1)) begin
               state_in = ST_MAXQ;
            end else begin
               cnt_in = cnt_ff + CNT_BITS'(1);
            end
         end
         ST_MAXQ: begin
            inj_in   = '{valid: 1'b1, mode: MODE_MAX, data: '0};
            state_in = ST_FLUSH;
         end
         ST_FLUSH: begin
            if (exit_token) begin
               s1_in    = links[0].data;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_sum_in     = sum;
               rsp_valid_in   = 1'b1;
               running_xor_in = '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      s1_ff      <= s1_in;
      rsp_sum_ff <= rsp_sum_in;
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         inj_ff         <= '0;
         running_xor_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_ff         <= cnt_in;
         inj_ff         <= inj_in;
         running_xor_ff <= running_xor_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign req_chan.ready    = (state_ff == ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.best_sum = rsp_sum_ff;

   `XBS_ASSERT_IMPL(a_token_in_flush, clock, reset, exit_token, state_ff == ST_FLUSH)
   `XBS_ASSERT_IMPL(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH)
   `XBS_ASSERT_IMPL(a_load_chain_idle, clock, reset, ctl.load_old, !links[WORD_BITS].valid)

endmodule

### src/xbs_cell.sv
// one pivot cell of the gf(2) basis chain: owns one bit position
// depends on xbs_pkg and xor_basis_max_split_sum_top_defines.svh
`include "xor_basis_max_split_sum_top_defines.svh"

module xbs_cell import xbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [WORD_BITS-1:0] bit_sel,
   input  ctl_type              ctl,
   input  link_type             link_in,
   output link_type             link_out,
   input  old_type              old_in,
   output old_type              old_out
);

   logic                 has_ff, has_in;
   logic [WORD_BITS-1:0] pivot_ff, pivot_in;
   link_type             link_ff, link_in_nxt;
   old_type              old_ff, old_in_nxt;

   // reduce or install the passing transaction
   always_comb begin
      logic hit;
      hit         = |(link_in.data & bit_sel);
      link_in_nxt = link_in;
      has_in      = has_ff;
      pivot_in    = pivot_ff;
      if (link_in.valid) begin
         case (link_in.mode)
            MODE_INSERT: begin
               if (hit) begin
                  if (has_ff) begin
                     link_in_nxt.data = link_in.data ^ pivot_ff;
                  end else begin
                     pivot_in          = link_in.data;
                     has_in            = 1'b1;
                     link_in_nxt.valid = 1'b0;
                  end
               end
            end
            MODE_MAX: begin
               // greedy max: take the pivot when its leading bit is still zero
               if (has_ff && !hit) begin
                  link_in_nxt.data = link_in.data ^ pivot_ff;
               end
            end
            default: begin
               link_in_nxt.valid = 1'b0;
            end
         endcase
      end
      if (ctl.clear || ctl.load_old) begin
         has_in = 1'b0;
      end
   end

   // saved basis bank: parallel load, then shift toward the top
   always_comb begin
      old_in_nxt = old_ff;
      if (ctl.load_old) begin
         old_in_nxt.has = has_ff;
         old_in_nxt.vec = pivot_ff;
      end else if (ctl.shift_old) begin
         old_in_nxt = old_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         has_ff  <= 1'b0;
         link_ff <= '0;
         old_ff  <= '0;
      end else begin
         has_ff  <= has_in;
         link_ff <= link_in_nxt;
         old_ff  <= old_in_nxt;
      end
   end

   // pivot payload
   always_ff @(posedge clock) begin
      pivot_ff <= pivot_in;
   end

   assign link_out = link_ff;
   assign old_out  = old_ff;

   `XBS_ASSERT_IMPL(a_pivot_bit, clock, reset, has_ff, (pivot_ff & bit_sel) != '0)
   `XBS_ASSERT_IMPL(a_insert_cleared, clock, reset, link_ff.valid && link_ff.mode == MODE_INSERT, (link_ff.data & bit_sel) == '0)
   `XBS_ASSERT_IMPL(a_install_src, clock, reset, $rose(has_ff), $past(link_in.valid) && $past(link_in.mode) == MODE_INSERT)

endmodule
